// ===== src/playlist_track_selector_assert.svh =====
// Assertion helpers shared by the RTL. All sample on the rising clock edge and
// are disabled while reset is high.
`ifndef PLAYLIST_TRACK_SELECTOR_ASSERT_SVH
`define PLAYLIST_TRACK_SELECTOR_ASSERT_SVH

// Same-cycle implication.
`define PTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pts assertion failed");

// Next-cycle implication.
`define PTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pts assertion failed");

`endif

// ===== src/pts_pkg.sv =====
package pts_pkg;

   localparam int MAX_TRACKS = 256;
   localparam int IDX_W      = $clog2(MAX_TRACKS);
   localparam int CNT_W      = 9;
   localparam int SEED_W     = 10;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;

   localparam logic [ADDR_W-3:0] REG_TRACK_COUNT = 1'b0;
   localparam logic [ADDR_W-3:0] REG_SHUFFLE     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_CHECK,
      ST_CLEAR,
      ST_REDUCE,
      ST_PICK,
      ST_FINISH,
      ST_INIT
   } pts_state_type;

endpackage

// ===== src/pts_if.sv =====
interface pts_req_bus import pts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [SEED_W-1:0] seed;

   modport source (output valid, output func, output seed, input ready);
   modport sink (input valid, input func, input seed, output ready);
endinterface

interface pts_rsp_bus import pts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] track_index;
   logic             refilled;

   modport source (output valid, output track_index, output refilled, input ready);
   modport sink (input valid, input track_index, input refilled, output ready);
endinterface

// ===== src/playlist_track_selector.sv =====
// Flow from accepted request to valid result word: sequential mode goes straight to the
// finish state. Shuffle mode counts the unplayed marks, checks the count, clears the marks
// (refill only), reduces the seed (0 taken as the unplayed count) by that count, scans for
// the picked index and finishes; finishing waits for the output word slot.
// Throughput: one request at a time; ready again in the cycle the result word turns valid.
// Reset (synchronous): track_count=1, shuffle off, current track 0; an init pass then
// clears every mark while the request side is held not ready.
`include "playlist_track_selector_assert.svh"

module playlist_track_selector import pts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pts_req_bus.sink          req_bus,
   pts_rsp_bus.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   pts_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      track_count_ff, track_count_in;
   logic                  shuffle_ff, shuffle_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SEED_W-1:0]     rem_ff, rem_in;
   logic [SEED_W-1:0]     seed_ff, seed_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic                  refill_ff, refill_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic                  rsp_refill_ff, rsp_refill_in;

   logic                  played_mem [MAX_TRACKS];
   logic                  played_rd_ff;
   logic                  mark_we;
   logic [IDX_W-1:0]      mark_addr;
   logic                  mark_bit;

   logic [CNT_W-1:0]      n_eff;
   logic [CNT_W-1:0]      n_m1;
   logic [IDX_W-1:0]      seq_pick;
   logic [CNT_W-1:0]      cnt_eff;
   logic [SEED_W-1:0]     target;
   logic                  cfg_wr;

   // Configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      track_count_in = track_count_ff;
      shuffle_in     = shuffle_ff;
      prdata         = '0;
      case (paddr[ADDR_W-1:2])
         REG_TRACK_COUNT: begin
            prdata = DATA_W'(track_count_ff);
            if (cfg_wr) begin
               track_count_in = pwdata[CNT_W-1:0];
            end
         end
         REG_SHUFFLE: begin
            prdata = DATA_W'(shuffle_ff);
            if (cfg_wr) begin
               shuffle_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Saturate the count into 1..MAX_TRACKS
   always_comb begin
      if (track_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (track_count_ff > CNT_W'(MAX_TRACKS)) begin
         n_eff = CNT_W'(MAX_TRACKS);
      end else begin
         n_eff = track_count_ff;
      end
      n_m1 = n_eff - CNT_W'(1);
   end

   always_comb begin
      if (req_bus.func == 1'b0) begin
         seq_pick = ({1'b0, cur_ff} >= n_m1) ? '0 : cur_ff + IDX_W'(1);
      end else begin
         seq_pick = (cur_ff == '0) ? n_m1[IDX_W-1:0] : cur_ff - IDX_W'(1);
      end
   end

   assign cnt_eff = (cnt_ff == '0) ? n_eff : cnt_ff;
   assign target  = (seed_ff == '0) ? SEED_W'(cnt_eff) : seed_ff;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.track_index = rsp_idx_ff;
   assign rsp_bus.refilled    = rsp_refill_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      seed_in       = seed_ff;
      pick_in       = pick_ff;
      refill_in     = refill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_refill_in = rsp_refill_ff;
      mark_we       = 1'b0;
      mark_addr     = idx_ff[IDX_W-1:0];
      mark_bit      = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // clear every mark once after reset
            mark_we = 1'b1;
            idx_in  = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(MAX_TRACKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               refill_in = 1'b0;
               seed_in   = req_bus.seed;
               if (shuffle_ff) begin
                  idx_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_COUNT;
               end else begin
                  pick_in  = seq_pick;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_COUNT: begin
            if (!played_rd_ff) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == n_m1) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Everything played: clear the marks below the count and start over
            if (cnt_ff == '0) begin
               refill_in = 1'b1;
               idx_in    = '0;
               state_in  = ST_CLEAR;
            end else begin
               state_in = ST_REDUCE;
            end
            cnt_in = cnt_eff;
            rem_in = target - SEED_W'(1);
         end
         ST_CLEAR: begin
            mark_we = 1'b1;
            idx_in  = idx_ff + CNT_W'(1);
            if (idx_ff == n_m1) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (rem_ff >= SEED_W'(cnt_ff)) begin
               rem_in = rem_ff - SEED_W'(cnt_ff);
            end else begin
               idx_in   = '0;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // rem counts down the unplayed entries still to skip
            if (!played_rd_ff) begin
               if (rem_ff == '0) begin
                  pick_in  = idx_ff[IDX_W-1:0];
                  state_in = ST_FINISH;
               end else begin
                  rem_in = rem_ff - SEED_W'(1);
               end
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         ST_FINISH: begin
            // Hold until the output word slot frees up
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = pick_ff;
               rsp_refill_in = refill_ff;
               mark_we       = 1'b1;
               mark_addr     = pick_ff;
               mark_bit      = 1'b1;
               cur_in        = pick_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         track_count_ff <= CNT_W'(1);
         shuffle_ff     <= 1'b0;
         cur_ff         <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         track_count_ff <= track_count_in;
         shuffle_ff     <= shuffle_in;
         cur_ff         <= cur_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      seed_ff       <= seed_in;
      pick_ff       <= pick_in;
      refill_ff     <= refill_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_refill_ff <= rsp_refill_in;
   end

   // Mark memory; read ahead on idx_in so the mark of idx_ff is ready in the same cycle as idx_ff
   always_ff @(posedge clock) begin
      if (mark_we) begin
         played_mem[mark_addr] <= mark_bit;
      end
      played_rd_ff <= played_mem[idx_in[IDX_W-1:0]];
   end

   `PTS_ASSERT_NOW(a_reduce_nonzero, state_ff == ST_REDUCE, cnt_ff != '0)
   `PTS_ASSERT_NOW(a_pick_in_range, state_ff == ST_PICK, rem_ff < SEED_W'(cnt_ff))
   `PTS_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)
   `PTS_ASSERT_NEXT(a_commit_marks, mark_we && mark_bit, rsp_valid_ff && rsp_idx_ff == cur_ff)

endmodule
